// ===== hw/rtl/polyline_stroke_extruder_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the polyline stroke extruder
// Shared property wrappers used by the controller and the datapath.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_STROKE_EXTRUDER_ASSERT_SVH
`define POLYLINE_STROKE_EXTRUDER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PSE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg
// Types, codes and constants shared by the stroke extruder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_SCALE,
        ST_EMIT
    } pse_state_t;

    localparam int ROOT_BITS       = 16;
    localparam int ROOT_IDX_W      = 4;
    localparam int NORM_LIMIT_BITS = 15;
    localparam int CFG_W           = 16;
    localparam int PHASE_W         = 16;
    localparam int HW_W            = 8;
    localparam int OUT_W           = 25;
    localparam int GREY_W          = 8;
    localparam int SQ_W            = 30;
    localparam int ACC_W           = 64;
    localparam int OFF_W           = 18;

    typedef struct packed {
        logic                  restart;
        logic                  load_first;
        logic                  load_flush;
        logic                  norm_shift;
        logic                  square;
        logic                  sum;
        logic                  root_step;
        logic [ROOT_IDX_W-1:0] bit_idx;
        logic                  scale;
        logic                  load_out;
    } pse_cmd_t;

    typedef struct packed {
        logic norm_done;
        logic out_free;
    } pse_status_t;

    // register indexes
    localparam logic [1:0] REG_HALF_WIDTH   = 2'd0;
    localparam logic [1:0] REG_PHASE_STEP_A = 2'd1;
    localparam logic [1:0] REG_PHASE_STEP_B = 2'd2;

    // points held on the current line
    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_ONE  = 2'd1;
    localparam logic [1:0] PH_MORE = 2'd2;

    localparam logic [HW_W-1:0]    HALF_WIDTH_RST   = 8'd10;
    localparam logic [PHASE_W-1:0] PHASE_STEP_A_RST = 16'd1043;
    localparam logic [PHASE_W-1:0] PHASE_STEP_B_RST = 16'd1460;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned GREY_MID    = 64'd127;
    localparam longint unsigned GREY_MAX    = 64'd254;

    localparam longint unsigned TAYLOR_DEN [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    // Q30 sine on 0..pi/2, Taylor series
    function automatic longint unsigned sine_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned acc;
        x2   = (x * x) >> 30;
        term = x;
        acc  = x;
        for (int n = 1; n <= 8; n++) begin
            term = (term * x2) >> 30;
            term = term / TAYLOR_DEN[n-1];
            if ((n % 2) == 1) begin
                acc = (acc >= term) ? acc - term : 64'd0;
            end else begin
                acc = acc + term;
            end
        end
        return acc;
    endfunction

    // grey level for an angle in Q30 radians over 0..2pi
    function automatic logic [GREY_W-1:0] grey_entry(input longint unsigned th_in);
        longint unsigned th;
        longint unsigned mag;
        longint unsigned total;
        longint unsigned g;
        logic            neg;
        th  = th_in;
        neg = 1'b0;
        if (th > PI_Q30) begin
            th  = th - PI_Q30;
            neg = 1'b1;
        end
        if (th > HALF_PI_Q30) begin
            th = (th <= PI_Q30) ? PI_Q30 - th : 64'd0;
        end
        mag = sine_q30(th);
        if (mag > Q30_ONE) begin
            mag = Q30_ONE;
        end
        if (neg) begin
            total = GREY_MID * Q30_ONE - GREY_MID * mag;
        end else begin
            total = GREY_MID * Q30_ONE + GREY_MID * mag;
        end
        g = total >> 30;
        if (g > GREY_MAX) begin
            g = GREY_MAX;
        end
        return g[GREY_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pse_datapath.sv =====
// ----------------------------------------------------------------------------
// pse_datapath
// Point history, normal computation (shift, square, bit-serial root, scale),
// grey lookup and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polyline_stroke_extruder_assert.svh"

module pse_datapath #(
    parameter int COORD_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire pse_pkg::pse_cmd_t                 cmd,
    output pse_pkg::pse_status_t                   status,
    input  wire logic                              cfg_wr_en,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [pse_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire logic signed [COORD_BITS-1:0]      in_x,
    input  wire logic signed [COORD_BITS-1:0]      in_y,
    input  wire logic [pse_pkg::PHASE_W-1:0]       in_base_a,
    input  wire logic [pse_pkg::PHASE_W-1:0]       in_base_b,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [pse_pkg::OUT_W-1:0]              out_left_x,
    output logic [pse_pkg::OUT_W-1:0]              out_left_y,
    output logic [pse_pkg::OUT_W-1:0]              out_right_x,
    output logic [pse_pkg::OUT_W-1:0]              out_right_y,
    output logic [pse_pkg::GREY_W-1:0]             out_grey_left,
    output logic [pse_pkg::GREY_W-1:0]             out_grey_right,
    output logic                                   out_end
);
    import pse_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int IW = $clog2(SINE_TABLE_DEPTH);
    localparam int PW = PHASE_W + IW + 1;
    localparam int WW = 34;
    localparam int PROD_W = HW_W + ROOT_BITS + 1;

    // configuration
    logic [HW_W-1:0]    half_width_reg;
    logic [PHASE_W-1:0] step_a_reg, step_b_reg;

    // line history
    logic signed [COORD_BITS-1:0] earlier_x_reg, earlier_y_reg, held_x_reg, held_y_reg;
    logic [PHASE_W-1:0]           acc_a_reg, acc_b_reg;

    // working set for one strip step
    logic signed [COORD_BITS-1:0] p_x_reg, p_y_reg;
    logic [DW-1:0]                mag_x_reg, mag_y_reg;
    logic                         neg_ox_reg, neg_oy_reg;
    logic [PHASE_W-1:0]           ga_reg, gb_reg;
    logic                         end_reg;
    logic [SQ_W-1:0]              sa_reg, sb_reg;
    logic                         szero_reg;
    logic [ACC_W-1:0]             b_reg, ax_reg, ay_reg, q2x_reg, q2y_reg;
    logic [ROOT_BITS-1:0]         qx_reg, qy_reg;
    logic [OFF_W-1:0]             offx_reg, offy_reg;
    logic                         out_valid_reg;

    logic signed [DW-1:0] dx_next, dy_next;
    logic [NORM_LIMIT_BITS-1:0] ah, bh;
    logic [SQ_W:0]        s_sum;
    logic [ACC_W-1:0]     rhs_x, rhs_y, cand_x, cand_y, b_dbl;
    logic                 take_x, take_y;
    logic [ROOT_BITS-1:0] bit_mask;
    logic [PROD_W-1:0]    prod_x, prod_y;
    logic signed [WW-1:0] cx, cy, ox, oy, lx, ly, rx, ry;
    logic [PW-1:0]        pa, pb;
    logic [GREY_W-1:0]    grey_rom [SINE_TABLE_DEPTH];
    logic                 out_free;

    // grey table, one constant entry per phase step
    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
        localparam longint unsigned TH = (longint'(k) * TWO_PI_Q30) / SINE_TABLE_DEPTH;
        assign grey_rom[k] = grey_entry(TH);
    end

    // difference next - previous; a flush uses the held point as next
    always_comb begin
        if (cmd.load_flush) begin
            dx_next = {held_x_reg[COORD_BITS-1], held_x_reg}
                    - {earlier_x_reg[COORD_BITS-1], earlier_x_reg};
            dy_next = {held_y_reg[COORD_BITS-1], held_y_reg}
                    - {earlier_y_reg[COORD_BITS-1], earlier_y_reg};
        end else begin
            dx_next = {in_x[COORD_BITS-1], in_x}
                    - {earlier_x_reg[COORD_BITS-1], earlier_x_reg};
            dy_next = {in_y[COORD_BITS-1], in_y}
                    - {earlier_y_reg[COORD_BITS-1], earlier_y_reg};
        end
    end

    assign ah     = NORM_LIMIT_BITS'(mag_x_reg);
    assign bh     = NORM_LIMIT_BITS'(mag_y_reg);
    assign s_sum  = {1'b0, sa_reg} + {1'b0, sb_reg};
    // x offset follows |dy|, y offset follows |dx|
    assign rhs_x  = ACC_W'(sb_reg) << 30;
    assign rhs_y  = ACC_W'(sa_reg) << 30;
    assign b_dbl  = b_reg << 1;
    assign cand_x = q2x_reg + ax_reg + b_reg;
    assign cand_y = q2y_reg + ay_reg + b_reg;
    assign take_x = cand_x <= rhs_x;
    assign take_y = cand_y <= rhs_y;
    assign bit_mask = ROOT_BITS'(1) << cmd.bit_idx;
    assign prod_x = PROD_W'(half_width_reg) * PROD_W'(qx_reg) + PROD_W'(64);
    assign prod_y = PROD_W'(half_width_reg) * PROD_W'(qy_reg) + PROD_W'(64);

    always_comb begin
        cx = {{(WW-COORD_BITS){p_x_reg[COORD_BITS-1]}}, p_x_reg} <<< 8;
        cy = {{(WW-COORD_BITS){p_y_reg[COORD_BITS-1]}}, p_y_reg} <<< 8;
        ox = neg_ox_reg ? -$signed(WW'(offx_reg)) : $signed(WW'(offx_reg));
        oy = neg_oy_reg ? -$signed(WW'(offy_reg)) : $signed(WW'(offy_reg));
        lx = cx - ox;
        ly = cy - oy;
        rx = cx + ox;
        ry = cy + oy;
    end

    assign pa = PW'(ga_reg) * PW'(SINE_TABLE_DEPTH);
    assign pb = PW'(gb_reg) * PW'(SINE_TABLE_DEPTH);

    assign out_free         = !out_valid_reg || m_tready;
    assign status.out_free  = out_free;
    assign status.norm_done = ((mag_x_reg >> NORM_LIMIT_BITS) == '0)
                           && ((mag_y_reg >> NORM_LIMIT_BITS) == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg <= HALF_WIDTH_RST;
            step_a_reg     <= PHASE_STEP_A_RST;
            step_b_reg     <= PHASE_STEP_B_RST;
            earlier_x_reg  <= '0;
            earlier_y_reg  <= '0;
            held_x_reg     <= '0;
            held_y_reg     <= '0;
            acc_a_reg      <= '0;
            acc_b_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_HALF_WIDTH:   half_width_reg <= cfg_wdata[HW_W-1:0];
                    REG_PHASE_STEP_A: step_a_reg     <= cfg_wdata[PHASE_W-1:0];
                    REG_PHASE_STEP_B: step_b_reg     <= cfg_wdata[PHASE_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.restart) begin
                acc_a_reg     <= in_base_a;
                acc_b_reg     <= in_base_b;
                held_x_reg    <= in_x;
                held_y_reg    <= in_y;
                earlier_x_reg <= in_x;
                earlier_y_reg <= in_y;
            end else if (cmd.load_first) begin
                acc_a_reg     <= acc_a_reg + step_a_reg;
                acc_b_reg     <= acc_b_reg + step_b_reg;
                earlier_x_reg <= held_x_reg;
                earlier_y_reg <= held_y_reg;
                held_x_reg    <= in_x;
                held_y_reg    <= in_y;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_first || cmd.load_flush) begin
            p_x_reg    <= held_x_reg;
            p_y_reg    <= held_y_reg;
            ga_reg     <= acc_a_reg;
            gb_reg     <= acc_b_reg;
            end_reg    <= cmd.load_flush;
            mag_x_reg  <= dx_next[DW-1] ? -dx_next : dx_next;
            mag_y_reg  <= dy_next[DW-1] ? -dy_next : dy_next;
            neg_ox_reg <= !dy_next[DW-1] && (dy_next != '0);
            neg_oy_reg <= dx_next[DW-1];
        end
        if (cmd.norm_shift) begin
            mag_x_reg <= mag_x_reg >> 1;
            mag_y_reg <= mag_y_reg >> 1;
        end
        if (cmd.square) begin
            sa_reg <= ah * ah;
            sb_reg <= bh * bh;
        end
        if (cmd.sum) begin
            szero_reg <= (s_sum == '0);
            b_reg     <= ACC_W'(s_sum) << 30;
            ax_reg    <= '0;
            ay_reg    <= '0;
            q2x_reg   <= '0;
            q2y_reg   <= '0;
            qx_reg    <= '0;
            qy_reg    <= '0;
        end
        // one root bit per step, partial products kept pre-shifted
        if (cmd.root_step) begin
            b_reg <= b_reg >> 2;
            if (take_x) begin
                q2x_reg <= cand_x;
                ax_reg  <= (ax_reg + b_dbl) >> 1;
                qx_reg  <= qx_reg | bit_mask;
            end else begin
                ax_reg <= ax_reg >> 1;
            end
            if (take_y) begin
                q2y_reg <= cand_y;
                ay_reg  <= (ay_reg + b_dbl) >> 1;
                qy_reg  <= qy_reg | bit_mask;
            end else begin
                ay_reg <= ay_reg >> 1;
            end
        end
        if (cmd.scale) begin
            offx_reg <= szero_reg ? '0 : OFF_W'(prod_x >> 7);
            offy_reg <= szero_reg ? '0 : OFF_W'(prod_y >> 7);
        end
        if (cmd.load_out) begin
            out_left_x     <= lx[OUT_W-1:0];
            out_left_y     <= ly[OUT_W-1:0];
            out_right_x    <= rx[OUT_W-1:0];
            out_right_y    <= ry[OUT_W-1:0];
            out_grey_left  <= grey_rom[pa[PHASE_W +: IW]];
            out_grey_right <= grey_rom[pb[PHASE_W +: IW]];
            out_end        <= end_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    `PSE_ASSERT_IMPL(a_load_only_when_free, aclk, aresetn, cmd.load_out, out_free, "result overwritten")
    `PSE_ASSERT_IMPL(a_single_capture, aclk, aresetn, cmd.load_first, !cmd.load_flush && !cmd.restart, "two captures at once")
    `PSE_ASSERT_NEXT(a_result_held, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

endmodule

`default_nettype wire

// ===== hw/rtl/pse_controller.sv =====
// ----------------------------------------------------------------------------
// pse_controller
// Sequencer: line bookkeeping and the per-step command schedule.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polyline_stroke_extruder_assert.svh"

module pse_controller (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic                 in_start,
    input  wire logic                 in_end,
    input  wire pse_pkg::pse_status_t status,
    output pse_pkg::pse_cmd_t         cmd
);
    import pse_pkg::*;

    pse_state_t            state_reg, state_next;
    logic [ROOT_IDX_W-1:0] bit_reg;
    logic [1:0]            ph_reg;
    logic                  flush_reg;
    logic                  accept;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            bit_reg   <= '0;
            ph_reg    <= PH_NONE;
            flush_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.restart) begin
                ph_reg <= in_end ? PH_NONE : PH_ONE;
            end else if (cmd.load_first) begin
                ph_reg    <= in_end ? PH_NONE : PH_MORE;
                flush_reg <= in_end;
            end else if (cmd.load_flush) begin
                flush_reg <= 1'b0;
            end
            if (cmd.sum) begin
                bit_reg <= ROOT_IDX_W'(ROOT_BITS - 1);
            end else if (cmd.root_step) begin
                bit_reg <= bit_reg - 1'b1;
            end
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.bit_idx = bit_reg;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (in_start || ph_reg == PH_NONE) begin
                        cmd.restart = 1'b1;
                    end else begin
                        cmd.load_first = 1'b1;
                        state_next     = ST_NORM;
                    end
                end
            end
            ST_NORM: begin
                if (status.norm_done) begin
                    state_next = ST_SQUARE;
                end else begin
                    cmd.norm_shift = 1'b1;
                end
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (bit_reg == '0) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    if (flush_reg) begin
                        cmd.load_flush = 1'b1;
                        state_next     = ST_NORM;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `PSE_ASSERT_NEXT(a_first_point_held, aclk, aresetn, accept && (in_start || ph_reg == PH_NONE) && !in_end, ph_reg == PH_ONE, "first point not held")
    `PSE_ASSERT_NEXT(a_root_ends, aclk, aresetn, state_reg == ST_ROOT && bit_reg == '0, state_reg == ST_SCALE, "root did not finish")
    `PSE_ASSERT_IMPL(a_ready_only_idle, aclk, aresetn, s_tready, state_reg == ST_IDLE, "ready outside idle")

endmodule

`default_nettype wire

// ===== hw/rtl/polyline_stroke_extruder.sv =====
// ----------------------------------------------------------------------------
// polyline_stroke_extruder
// Turns polyline points into triangle-strip steps with per-vertex grey.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                        | side bits
//  s_       | in  | x_coord, y_coord, base_phase_a/b, pad     | tuser=start, tlast=end
//  m_       | out | left_x, left_y, right_x, right_y, greys   | tlast=end_of_strip
//  cfg_     | in  | index 0 half_width, 1 step_a, 2 step_b     | write only
//
//  A point that opens a line only loads the point and base phases. Any other point
//  runs a strip step built around the 16-step bit-serial square root; a point
//  ending a line runs two steps back to back.
//  Reset is synchronous, active low; no clearing pass.
//  A stalled m_ side holds the finished item; the next step waits only at load.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_stroke_extruder #(
    parameter int COORD_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 256,
    localparam int S_DATA_W = ((2 * COORD_BITS + 32 + 7) / 8) * 8,
    localparam int M_DATA_W = 120
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // x_coord, y_coord, base_phase_a, base_phase_b, zero pad
    input  wire logic [S_DATA_W-1:0]       s_tdata,
    // start_of_line
    input  wire logic                      s_tuser,
    input  wire logic                      s_tlast,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // left_x, left_y, right_x, right_y, grey_left, grey_right, zero pad
    output logic [M_DATA_W-1:0]            m_tdata,
    output logic                           m_tlast,
    input  wire logic                      cfg_wr_en,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [pse_pkg::CFG_W-1:0] cfg_wdata
);
    import pse_pkg::*;

    localparam int PAD_W = M_DATA_W - 4 * OUT_W - 2 * GREY_W;

    pse_cmd_t    cmd;
    pse_status_t status;

    logic signed [COORD_BITS-1:0] in_x, in_y;
    logic [PHASE_W-1:0]           in_base_a, in_base_b;
    logic [OUT_W-1:0]             lx, ly, rx, ry;
    logic [GREY_W-1:0]            gl, gr;

    assign in_x      = s_tdata[COORD_BITS-1:0];
    assign in_y      = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_base_a = s_tdata[2*COORD_BITS +: PHASE_W];
    assign in_base_b = s_tdata[2*COORD_BITS+PHASE_W +: PHASE_W];

    pse_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_start (s_tuser),
        .in_end   (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    pse_datapath #(
        .COORD_BITS       (COORD_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_x           (in_x),
        .in_y           (in_y),
        .in_base_a      (in_base_a),
        .in_base_b      (in_base_b),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .out_left_x     (lx),
        .out_left_y     (ly),
        .out_right_x    (rx),
        .out_right_y    (ry),
        .out_grey_left  (gl),
        .out_grey_right (gr),
        .out_end        (m_tlast)
    );

    assign m_tdata = {{PAD_W{1'b0}}, gr, gl, ry, rx, ly, lx};

endmodule

`default_nettype wire

// ===== verif/stroke_checker.sv =====
// ----------------------------------------------------------------------------
// Stroke extruder checker
// Watches the point and strip-step channels, predicts each strip step from
// the accepted points and the register values, and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module stroke_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [63:0]  s_tdata,
    input  wire logic         s_tuser,
    input  wire logic         s_tlast,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [119:0] m_tdata,
    input  wire logic         m_tlast,
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_wdata,
    output int                err_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pse_pkg::*;

    typedef struct packed {
        logic [24:0] lx, ly, rx, ry;
        logic [7:0]  gl, gr;
        logic        eos;
    } step_t;

    step_t steps_due[$];
    logic [7:0] grey_lut [256];

    logic [7:0]  half_w;
    logic [15:0] step_a, step_b;
    longint      prev_x, prev_y, hold_x, hold_y;
    logic [1:0]  held;
    logic [15:0] acc_a, acc_b;

    // Q30 sine by Taylor series, own copy
    function automatic longint unsigned taylor_sin(longint unsigned x);
        longint unsigned x2, t, s;
        x2 = (x * x) >> 30;
        t = x;
        s = x;
        for (int n = 1; n <= 8; n++) begin
            t = (t * x2) >> 30;
            t = t / ((2 * n) * (2 * n + 1));
            if (n % 2) s = (s >= t) ? s - t : 0;
            else s = s + t;
        end
        return s;
    endfunction

    initial begin
        longint unsigned th, mag, g;
        logic neg;
        for (int k = 0; k < 256; k++) begin
            th = (longint'(k) * 64'd6746518852) / 256;
            neg = 0;
            if (th > 64'd3373259426) begin
                th -= 64'd3373259426;
                neg = 1;
            end
            if (th > 64'd1686629713)
                th = (th <= 64'd3373259426) ? 64'd3373259426 - th : 0;
            mag = taylor_sin(th);
            if (mag > 64'd1073741824) mag = 64'd1073741824;
            g = neg ? (127 * 64'd1073741824 - 127 * mag) >> 30
                    : (127 * 64'd1073741824 + 127 * mag) >> 30;
            if (g > 254) g = 254;
            grey_lut[k] = g[7:0];
        end
    end

    function automatic longint unsigned normal_part(longint unsigned a,
                                                    longint unsigned b);
        longint unsigned s, rhs, q, c;
        q = 0;
        while (a >= 32768 || b >= 32768) begin
            a >>= 1;
            b >>= 1;
        end
        s = a * a + b * b;
        if (s == 0) return 0;
        rhs = (a * a) << 30;
        for (int i = 15; i >= 0; i--) begin
            c = q | (64'd1 << i);
            if (c * c * s <= rhs) q = c;
        end
        return (half_w * 256 * q + 16384) >> 15;
    endfunction

    function automatic step_t strip_step(longint px, longint py, longint ax,
                                         longint ay, longint bx, longint by,
                                         logic [15:0] pa, logic [15:0] pb,
                                         logic last);
        step_t r;
        longint dx, dy, ox, oy;
        dx = bx - ax;
        dy = by - ay;
        ox = normal_part(dy < 0 ? -dy : dy, dx < 0 ? -dx : dx);
        oy = normal_part(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
        if (dy > 0) ox = -ox;
        if (dx < 0) oy = -oy;
        r.lx = 25'(px * 256 - ox);
        r.ly = 25'(py * 256 - oy);
        r.rx = 25'(px * 256 + ox);
        r.ry = 25'(py * 256 + oy);
        r.gl = grey_lut[pa[15:8]];
        r.gr = grey_lut[pb[15:8]];
        r.eos = last;
        return r;
    endfunction

    task automatic take_point(logic [63:0] d, logic first, logic last);
        longint x, y;
        x = longint'($signed(d[15:0]));
        y = longint'($signed(d[31:16]));
        if (first || held == PH_NONE) begin
            acc_a = d[47:32];
            acc_b = d[63:48];
            hold_x = x;
            prev_x = x;
            hold_y = y;
            prev_y = y;
            held = last ? PH_NONE : PH_ONE;
        end else begin
            steps_due.push_back(strip_step(hold_x, hold_y, prev_x, prev_y, x, y,
                                           acc_a, acc_b, 1'b0));
            acc_a += step_a;
            acc_b += step_b;
            prev_x = hold_x;
            prev_y = hold_y;
            hold_x = x;
            hold_y = y;
            held = PH_MORE;
            if (last) begin
                steps_due.push_back(strip_step(x, y, prev_x, prev_y, x, y,
                                               acc_a, acc_b, 1'b1));
                held = PH_NONE;
            end
        end
    endtask

    task automatic check_step(step_t got);
        step_t e;
        if (steps_due.size() == 0) begin
            $error("unexpected strip step %h", got);
            err_count++;
            return;
        end
        e = steps_due.pop_front();
        if (got.lx !== e.lx) begin $error("left_x exp %h got %h", e.lx, got.lx); err_count++; end
        if (got.ly !== e.ly) begin $error("left_y exp %h got %h", e.ly, got.ly); err_count++; end
        if (got.rx !== e.rx) begin $error("right_x exp %h got %h", e.rx, got.rx); err_count++; end
        if (got.ry !== e.ry) begin $error("right_y exp %h got %h", e.ry, got.ry); err_count++; end
        if (got.gl !== e.gl) begin $error("grey_left exp %0d got %0d", e.gl, got.gl); err_count++; end
        if (got.gr !== e.gr) begin $error("grey_right exp %0d got %0d", e.gr, got.gr); err_count++; end
        if (got.eos !== e.eos) begin
            $error("end_of_strip exp %b got %b", e.eos, got.eos);
            err_count++;
        end
    endtask

    initial err_count = 0;
    assign pending = steps_due.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            half_w <= HALF_WIDTH_RST;
            step_a <= PHASE_STEP_A_RST;
            step_b <= PHASE_STEP_B_RST;
            held = PH_NONE;
            prev_x = 0; prev_y = 0; hold_x = 0; hold_y = 0;
            acc_a = 0; acc_b = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_HALF_WIDTH: half_w <= cfg_wdata[7:0];
                    REG_PHASE_STEP_A: step_a <= cfg_wdata;
                    REG_PHASE_STEP_B: step_b <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) take_point(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready)
                check_step({m_tdata[99:0], m_tdata[111:100], m_tlast} == 0 ?
                           step_t'({m_tdata[24:0], m_tdata[49:25], m_tdata[74:50],
                                    m_tdata[99:75], m_tdata[107:100],
                                    m_tdata[115:108], m_tlast}) :
                           step_t'({m_tdata[24:0], m_tdata[49:25], m_tdata[74:50],
                                    m_tdata[99:75], m_tdata[107:100],
                                    m_tdata[115:108], m_tlast}));
        end
    end
endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Stroke extruder testbench
// Drives directed and random polylines with random idling on both channels,
// rewrites the registers between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pse_pkg::*;

    localparam int WATCHDOG = 20000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0, s_tuser = 0, s_tlast = 0;
    logic [63:0]  s_tdata = 0;
    logic         s_tready;
    logic         m_tvalid, m_tlast;
    logic         m_tready = 0;
    logic [119:0] m_tdata;
    logic         cfg_wr_en = 0;
    logic [1:0]   cfg_index = REG_HALF_WIDTH;
    logic [15:0]  cfg_wdata = 0;
    int           err_count, pending;
    bit           quiet = 0;
    int           idle_cycles = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    polyline_stroke_extruder dut (.*);
    stroke_checker chk (.*);

    // result side: random stall bursts, none in the quiet tail
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (!quiet && $urandom_range(0, 9) == 0) begin
                m_tready <= 0;
                gap = $urandom_range(1, 19);
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_point(logic [15:0] x, logic [15:0] y, logic first, logic last,
                              logic [15:0] pa, logic [15:0] pb);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {pb, pa, y, x};
        s_tuser <= first;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 0;
        while (pending != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 0;
    endtask

    function automatic logic [15:0] rnd_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 40) - 20);
            default: return ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
        endcase
    endfunction

    task automatic random_lines(int n_points);
        int sent, len, mode;
        logic [15:0] pa, pb;
        sent = 0;
        while (sent < n_points) begin
            len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
            mode = $urandom_range(0, 2);
            pa = 16'($urandom);
            pb = 16'($urandom);
            for (int i = 0; i < len; i++) begin
                // occasional stray restart or repeated point
                send_point(rnd_coord(mode), rnd_coord(mode),
                           i == 0 ? $urandom_range(0, 3) != 0 : $urandom_range(0, 30) == 0,
                           i == len - 1 ? $urandom_range(0, 7) != 0 : $urandom_range(0, 40) == 0,
                           pa, pb);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: extremes, zero difference, one-point lines, line ends
        send_point(16'h8000, 16'h8000, 1, 0, 16'h0000, 16'hffff);
        send_point(16'h7fff, 16'h7fff, 0, 0, 0, 0);
        send_point(16'h8000, 16'h7fff, 0, 0, 0, 0);
        send_point(16'h7fff, 16'h8000, 0, 1, 0, 0);
        send_point(16'd5, 16'd5, 1, 1, 16'h1234, 16'h4321);
        send_point(16'd5, 16'd5, 0, 0, 16'hffff, 16'h0);
        send_point(16'd5, 16'd5, 0, 0, 0, 0);
        send_point(16'd5, 16'd5, 0, 1, 0, 0);
        send_point(16'd0, 16'd0, 1, 0, 16'h8000, 16'h8000);
        send_point(16'd9, 16'd0, 1, 0, 0, 0);
        send_point(16'd0, 16'd1, 0, 1, 0, 0);
        send_point(16'hffff, 16'd3, 0, 0, 0, 0);
        send_point(16'hfff0, 16'd3, 0, 1, 0, 0);
        settle();

        write_reg(REG_HALF_WIDTH, 16'hffff);
        write_reg(REG_PHASE_STEP_A, 16'hffff);
        write_reg(REG_PHASE_STEP_B, 16'h0000);
        write_reg(2'd3, 16'h5555);
        random_lines(400);
        settle();

        write_reg(REG_HALF_WIDTH, 16'h0000);
        write_reg(REG_PHASE_STEP_A, 16'h0000);
        write_reg(REG_PHASE_STEP_B, 16'hffff);
        random_lines(300);
        settle();

        write_reg(REG_HALF_WIDTH, 16'($urandom));
        write_reg(REG_PHASE_STEP_A, 16'($urandom));
        write_reg(REG_PHASE_STEP_B, 16'($urandom));
        random_lines(550);
        quiet = 1;
        random_lines(300);
        s_tvalid <= 0;

        while (pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

`default_nettype wire
